// File: rtl/uqpd_pkg.sv
// shared types and constants for the url query pair decoder
// no dependencies; compiled first
package uqpd_pkg;

    // results one input byte can cause at most
    localparam int NUM_RES = 4;
    localparam int RES_CW  = $clog2(NUM_RES + 1);
    localparam int RES_IW  = $clog2(NUM_RES);

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_AMP   = 8'h26;

    typedef enum logic [2:0] {
        KIND_NAME    = 3'd0,
        KIND_VALUE   = 3'd1,
        KIND_KEPT    = 3'd2,
        KIND_DROPPED = 3'd3,
        KIND_END     = 3'd4
    } t_kind;

    // all results caused by one input byte
    typedef struct packed {
        logic [RES_CW-1:0]          cnt;
        t_kind [NUM_RES-1:0]        kind;
        logic  [NUM_RES-1:0][7:0]   data;
    } t_bundle;

endpackage

// File: rtl/uqpd_in_if.sv
// input channel: one raw query string byte per transaction
// no dependencies
interface uqpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

// File: rtl/uqpd_out_if.sv
// output channel: one decoded result per transaction
// no dependencies
interface uqpd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// File: rtl/url_query_pair_decoder.sv
// Streaming URL query string decoder. Raw bytes enter on i_char at up to one byte
// per cycle; the front part splits pairs at '&' and the first '=', decodes '+' and
// percent escapes and upper-cases name letters, and turns each byte into zero to four
// results (name byte, value byte, pair end kept or dropped, string end). These are
// held as one bundle in a queue of QUEUE_DEPTH entries, and the back part sends them
// on o_res one result per cycle while o_res.ready is high. Input is accepted every
// cycle while the queue has room, so the sustained byte rate is one per cycle until
// result traffic exceeds one per cycle, where the single output port sets the pace.
// From an empty queue, a result passes a queue entry and r_bun before o_res.
// depends on uqpd_pkg, uqpd_in_if, uqpd_out_if, uqpd_front, uqpd_fifo, uqpd_back
module url_query_pair_decoder #(
    parameter int QUEUE_DEPTH = uqpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uqpd_in_if.sink     i_char,
    uqpd_out_if.source  o_res
);
    import uqpd_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_bundle push_data;
    t_bundle pop_data;

    uqpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (push_data)
    );

    uqpd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (pop_data)
    );

    uqpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_bundle (pop_data),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

// File: rtl/uqpd_front.sv
// front part: splits pairs, decodes escapes and builds the result bundle of each byte
// depends on uqpd_pkg and uqpd_in_if
module uqpd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    uqpd_in_if.sink           i_char,
    input  logic              i_full,
    output logic              o_push,
    output uqpd_pkg::t_bundle o_bundle
);
    import uqpd_pkg::*;

    typedef enum logic [2:0] {
        PART_IDLE  = 3'b001,
        PART_NAME  = 3'b010,
        PART_VALUE = 3'b100
    } t_part;

    typedef enum logic [2:0] {
        ESC_NONE  = 3'b001,
        ESC_PCT   = 3'b010,
        ESC_DIGIT = 3'b100
    } t_esc;

    typedef struct packed {
        t_part      mode;
        t_esc       esc;
        logic [7:0] held;
        logic       trunc;
        t_bundle    res;
    } t_work;

    t_part      r_mode, n_mode;
    t_esc       r_esc, n_esc;
    logic [7:0] r_held, n_held;
    logic       r_trunc, n_trunc;
    t_work      w;
    logic       accept;

    function automatic logic f_hex_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] f_hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - (8'h61 - 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - (8'h41 - 8'd10);
        end
        return d[3:0];
    endfunction

    function automatic t_work f_put(input t_work wi, input t_kind k, input logic [7:0] b);
        t_work r;
        r = wi;
        if (r.res.cnt < RES_CW'(NUM_RES)) begin
            r.res.kind[r.res.cnt[RES_IW-1:0]] = k;
            r.res.data[r.res.cnt[RES_IW-1:0]] = b;
            r.res.cnt = r.res.cnt + RES_CW'(1);
        end
        return r;
    endfunction

    function automatic t_work f_emit(input t_work wi, input logic [7:0] b);
        t_work      r;
        logic [7:0] u;
        r = wi;
        u = b;
        if (!r.trunc) begin
            if (b == 8'h00) begin
                r.trunc = 1'b1;
            end else if (r.mode == PART_NAME) begin
                if (b >= 8'h61 && b <= 8'h7a) begin
                    u = b - 8'd32;
                end
                r = f_put(r, KIND_NAME, u);
            end else begin
                r = f_put(r, KIND_VALUE, b);
            end
        end
        return r;
    endfunction

    function automatic t_work f_decode(input t_work wi, input logic [7:0] c);
        t_work r;
        logic  done;
        r = wi;
        done = 1'b0;
        if (r.esc == ESC_PCT) begin
            if (f_hex_ok(c)) begin
                r.held = c;
                r.esc = ESC_DIGIT;
                done = 1'b1;
            end else begin
                r.esc = ESC_NONE;
            end
        end else if (r.esc == ESC_DIGIT) begin
            if (f_hex_ok(c)) begin
                r = f_emit(r, {f_hex_val(r.held), f_hex_val(c)});
                r.esc = ESC_NONE;
                r.held = 8'h00;
                done = 1'b1;
            end else begin
                r.esc = ESC_NONE;
                r = f_emit(r, r.held);
                r.held = 8'h00;
            end
        end
        if (!done) begin
            if (c == CH_PLUS) begin
                r = f_emit(r, CH_SPACE);
            end else if (c == CH_PCT) begin
                r.esc = ESC_PCT;
            end else begin
                r = f_emit(r, c);
            end
        end
        return r;
    endfunction

    function automatic t_work f_close_part(input t_work wi);
        t_work r;
        r = wi;
        if (r.esc == ESC_DIGIT) begin
            r = f_emit(r, r.held);
        end
        r.esc = ESC_NONE;
        r.held = 8'h00;
        r.trunc = 1'b0;
        return r;
    endfunction

    function automatic t_work f_end_pair(input t_work wi);
        t_work r;
        r = wi;
        if (r.mode != PART_IDLE) begin
            r = f_close_part(r);
            r = f_put(r, (r.mode == PART_VALUE) ? KIND_KEPT : KIND_DROPPED, 8'h00);
            r.mode = PART_IDLE;
        end
        return r;
    endfunction

    always_comb begin
        w.mode  = r_mode;
        w.esc   = r_esc;
        w.held  = r_held;
        w.trunc = r_trunc;
        w.res   = '0;
        if (i_char.char_in == CH_AMP) begin
            w = f_end_pair(w);
        end else if (i_char.char_in == CH_EQ && w.mode != PART_VALUE) begin
            if (w.mode == PART_NAME) begin
                w = f_close_part(w);
            end
            w.mode = PART_VALUE;
        end else begin
            if (w.mode == PART_IDLE) begin
                w.mode = PART_NAME;
            end
            w = f_decode(w, i_char.char_in);
        end
        if (i_char.is_last) begin
            w = f_end_pair(w);
            w = f_put(w, KIND_END, 8'h00);
            w.mode  = PART_IDLE;
            w.esc   = ESC_NONE;
            w.held  = 8'h00;
            w.trunc = 1'b0;
        end
    end

    assign i_char.ready = !i_full;
    assign accept       = i_char.valid && !i_full;
    // bytes that cause no result leave nothing in the queue
    assign o_push       = accept && (w.res.cnt != '0);
    assign o_bundle     = w.res;

    always_comb begin
        n_mode  = r_mode;
        n_esc   = r_esc;
        n_held  = r_held;
        n_trunc = r_trunc;
        if (accept) begin
            n_mode  = w.mode;
            n_esc   = w.esc;
            n_held  = w.held;
            n_trunc = w.trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= PART_IDLE;
            r_esc   <= ESC_NONE;
            r_held  <= 8'h00;
            r_trunc <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_esc   <= n_esc;
            r_held  <= n_held;
            r_trunc <= n_trunc;
        end
    end

endmodule

// File: rtl/uqpd_fifo.sv
// queue of result bundles between the front and back parts
// depends on uqpd_pkg
module uqpd_fifo #(
    parameter int DEPTH = uqpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  uqpd_pkg::t_bundle i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output uqpd_pkg::t_bundle o_data
);
    import uqpd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/uqpd_back.sv
// back part: sends the results of one bundle at a time, one per transaction
// depends on uqpd_pkg and uqpd_out_if
module uqpd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  uqpd_pkg::t_bundle i_bundle,
    output logic              o_pop,
    uqpd_out_if.source        o_res
);
    import uqpd_pkg::*;

    t_bundle           r_bun, n_bun;
    logic [RES_IW-1:0] r_idx, n_idx;
    logic              r_busy, n_busy;
    logic              take;
    logic              last;

    assign take  = r_busy && o_res.ready;
    assign last  = ({1'b0, r_idx} + RES_CW'(1)) == r_bun.cnt;
    // reload straight after the last result of a bundle goes out
    assign o_pop = !i_empty && (!r_busy || (take && last));

    assign o_res.valid     = r_busy;
    assign o_res.kind      = r_bun.kind[r_idx];
    assign o_res.data_byte = r_bun.data[r_idx];

    always_comb begin
        n_bun  = r_bun;
        n_idx  = r_idx;
        n_busy = r_busy;
        if (o_pop) begin
            n_bun  = i_bundle;
            n_idx  = '0;
            n_busy = 1'b1;
        end else if (take) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + RES_IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bun <= n_bun;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_busy <= n_busy;
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// testbench for url_query_pair_decoder: directed table then random query strings
// results are checked against a predictor in this file or a typed row's results
// depends on uqpd_pkg, uqpd_in_if, uqpd_out_if and the rtl of the block
module tb;
    import uqpd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 115;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {PM_BETWEEN, PM_NAME, PM_VALUE} t_part;
    typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_DIGIT} t_esc;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    // one stimulus row; typed rows carry their own results
    typedef struct packed {
        logic [7:0]      c;
        logic            last;
        logic            typed;
        logic [1:0]      n;
        t_kind [2:0]     k;
        logic [2:0][7:0] d;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    uqpd_in_if  char_bus ();
    uqpd_out_if res_bus ();

    url_query_pair_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_res   (res_bus)
    );

    // predictor state
    t_part      part_q;
    t_esc       esc_q;
    logic [7:0] held_q;
    logic       trunc_q;
    t_res       step_res[$];
    t_res       decoded_q[$];

    t_row       dir_rows[$];
    logic [7:0] query_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_req;
    int err_cnt;
    int cycle_cnt;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit is_hex(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nib(logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - 8'h30);
        if (c >= "a" && c <= "f") return 4'(c - 8'h61 + 8'd10);
        if (c >= "A" && c <= "F") return 4'(c - 8'h41 + 8'd10);
        return 4'd0;
    endfunction

    function automatic void put_res(t_kind k, logic [7:0] d);
        t_res r;
        if (step_res.size() >= NUM_RES) return;
        r.kind = k;
        r.data = d;
        step_res.push_back(r);
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        if (trunc_q) return;
        // a decoded zero cuts off the rest of the part
        if (b == 8'd0) begin
            trunc_q = 1'b1;
            return;
        end
        if (part_q == PM_NAME) begin
            if (b >= "a" && b <= "z") b = b - 8'd32;
            put_res(KIND_NAME, b);
        end else begin
            put_res(KIND_VALUE, b);
        end
    endfunction

    function automatic void decode_raw(logic [7:0] c);
        if (esc_q == ESC_PCT) begin
            if (is_hex(c)) begin
                held_q = c;
                esc_q  = ESC_DIGIT;
                return;
            end
            esc_q = ESC_IDLE;
        end else if (esc_q == ESC_DIGIT) begin
            if (is_hex(c)) begin
                emit_byte({hex_nib(held_q), hex_nib(c)});
                esc_q  = ESC_IDLE;
                held_q = 8'd0;
                return;
            end
            // broken escape, held digit goes out as is
            esc_q = ESC_IDLE;
            emit_byte(held_q);
            held_q = 8'd0;
        end
        if (c == CH_PLUS) emit_byte(CH_SPACE);
        else if (c == CH_PCT) esc_q = ESC_PCT;
        else emit_byte(c);
    endfunction

    function automatic void close_part();
        if (esc_q == ESC_DIGIT) emit_byte(held_q);
        esc_q   = ESC_IDLE;
        held_q  = 8'd0;
        trunc_q = 1'b0;
    endfunction

    function automatic void end_pair();
        if (part_q == PM_BETWEEN) return;
        close_part();
        put_res(part_q == PM_VALUE ? KIND_KEPT : KIND_DROPPED, 8'd0);
        part_q = PM_BETWEEN;
    endfunction

    function automatic void clear_state();
        part_q  = PM_BETWEEN;
        esc_q   = ESC_IDLE;
        held_q  = 8'd0;
        trunc_q = 1'b0;
    endfunction

    // fills step_res with the results of one raw byte
    function automatic void decode_char(logic [7:0] c, logic last);
        step_res.delete();
        if (c == CH_AMP) begin
            end_pair();
        end else if (c == CH_EQ && part_q != PM_VALUE) begin
            if (part_q == PM_NAME) close_part();
            part_q = PM_VALUE;
        end else begin
            if (part_q == PM_BETWEEN) part_q = PM_NAME;
            decode_raw(c);
        end
        if (last) begin
            end_pair();
            put_res(KIND_END, 8'd0);
            clear_state();
        end
    endfunction

    function automatic void add_row(logic [7:0] c, logic last, int n = -1,
                                    t_kind k0 = KIND_NAME, logic [7:0] d0 = 8'd0,
                                    t_kind k1 = KIND_NAME, logic [7:0] d1 = 8'd0,
                                    t_kind k2 = KIND_NAME, logic [7:0] d2 = 8'd0);
        t_row r;
        r       = '0;
        r.c     = c;
        r.last  = last;
        r.typed = (n >= 0);
        r.n     = (n >= 0) ? n[1:0] : 2'd0;
        r.k     = {k2, k1, k0};
        r.d     = {d2, d1, d0};
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] rnd_hex();
        case ($urandom_range(0, 2))
            0: return 8'("0" + $urandom_range(0, 9));
            1: return 8'("a" + $urandom_range(0, 5));
            default: return 8'("A" + $urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [7:0] rnd_plain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 8'("a" + $urandom_range(0, 25));
        if (r < 65) return 8'("A" + $urandom_range(0, 25));
        if (r < 80) return 8'("0" + $urandom_range(0, 9));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void push_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            query_q.push_back(rnd_plain());
        end else if (r < 65) begin
            query_q.push_back(CH_PLUS);
        end else if (r < 85) begin
            query_q.push_back(CH_PCT);
            if ($urandom_range(0, 9) == 0) begin
                query_q.push_back("0");
                query_q.push_back("0");
            end else begin
                query_q.push_back(rnd_hex());
                query_q.push_back(rnd_hex());
            end
        end else if (r < 95) begin
            // broken escapes of several shapes
            query_q.push_back(CH_PCT);
            case ($urandom_range(0, 3))
                0: query_q.push_back(8'("g" + $urandom_range(0, 19)));
                1: query_q.push_back(CH_PLUS);
                2: query_q.push_back(CH_PCT);
                default: begin
                    query_q.push_back(rnd_hex());
                    query_q.push_back(8'("g" + $urandom_range(0, 19)));
                end
            endcase
        end else begin
            // escape cut short, left open if a part boundary follows
            query_q.push_back(CH_PCT);
            if ($urandom_range(0, 1)) query_q.push_back(rnd_hex());
        end
    endfunction

    function automatic void build_query();
        int npairs;
        query_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) query_q.push_back(8'($urandom_range(1, 255)));
        end else begin
            npairs = $urandom_range(1, 4);
            for (int p = 0; p < npairs; p++) begin
                if ($urandom_range(0, 4) == 0) query_q.push_back(CH_AMP);
                repeat ($urandom_range(0, 4)) push_token();
                if ($urandom_range(0, 4) != 0) begin
                    query_q.push_back(CH_EQ);
                    repeat ($urandom_range(0, 5)) push_token();
                end
                if (p != npairs - 1 || $urandom_range(0, 7) == 0) query_q.push_back(CH_AMP);
            end
        end
        if (query_q.size() == 0) query_q.push_back(rnd_plain());
    endfunction

    task automatic note_error(string msg);
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT) $display("%s", msg);
    endtask

    // offers one byte, waits for the transaction and records what it should cause
    task automatic send_char(t_row r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            char_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        char_bus.valid   <= 1'b1;
        char_bus.char_in <= r.c;
        char_bus.is_last <= r.last;
        do @(posedge i_clk); while (char_bus.ready !== 1'b1);
        decode_char(r.c, r.last);
        if (r.typed) begin
            for (int i = 0; i < r.n; i++) decoded_q.push_back('{r.k[i], r.d[i]});
        end else begin
            foreach (step_res[i]) decoded_q.push_back(step_res[i]);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        char_bus.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_random(int s_idle, int r_idle);
        int sent;
        t_row r;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            build_query();
            foreach (query_q[i]) begin
                r      = '0;
                r.c    = query_q[i];
                r.last = (i == query_q.size() - 1);
                send_char(r);
            end
            sent += query_q.size();
        end
        wait_drained();
    endtask

    // receiver side: random stalls, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_res
        t_res want;
        if (i_rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (decoded_q.size() == 0) begin
                note_error($sformatf("unexpected result: kind %0d byte %02h",
                                     res_bus.kind, res_bus.data_byte));
            end else begin
                want = decoded_q.pop_front();
                if (res_bus.kind !== want.kind || res_bus.data_byte !== want.data)
                    note_error($sformatf(
                        "mismatch: expected kind %0d byte %02h, got kind %0d byte %02h",
                        want.kind, want.data, res_bus.kind, res_bus.data_byte));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        char_bus.valid   = 1'b0;
        char_bus.char_in = 8'h01;
        char_bus.is_last = 1'b0;
        res_bus.ready    = 1'b0;
        send_idle_pct    = 18;
        recv_idle_pct    = 46;
        hold_left        = 0;
        hold_req         = 1'b0;
        err_cnt          = 0;
        cycle_cnt        = 0;
        clear_state();

        // directed table: -1 means the predictor supplies the results
        add_row("x", 1'b1, 3, KIND_NAME, "X", KIND_DROPPED, 8'd0, KIND_END, 8'd0);
        add_row(CH_AMP, 1'b0, 0);               // empty pair at the start
        add_row(CH_EQ, 1'b0, 0);                // empty name
        add_row(8'hff, 1'b0, 1, KIND_VALUE, 8'hff);
        add_row(CH_PCT, 1'b0, 0);
        add_row("4", 1'b0);
        add_row("1", 1'b0);
        add_row(CH_PLUS, 1'b0);
        add_row(CH_EQ, 1'b0);                   // later '=' is a value byte
        add_row(CH_PCT, 1'b0);
        add_row("0", 1'b0);
        add_row("0", 1'b0);                     // decoded zero truncates the value
        add_row("z", 1'b0);
        add_row(CH_AMP, 1'b0, 1, KIND_KEPT, 8'd0);
        add_row("a", 1'b0);
        add_row(CH_PCT, 1'b0);
        add_row("6", 1'b0);
        add_row(CH_EQ, 1'b0);                   // held digit flushed at the '='
        add_row(CH_PCT, 1'b0);
        add_row("g", 1'b0);
        add_row(CH_PCT, 1'b0);
        add_row(CH_PLUS, 1'b0);
        add_row(CH_AMP, 1'b0);
        add_row("k", 1'b0);
        add_row(8'h01, 1'b1);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_char(dir_rows[i]);
        wait_drained();

        run_random(18, 46);
        run_random(46, 18);
        // output held off while input keeps coming, so the queue fills up
        hold_req = 1'b1;
        run_random(0, 0);

        repeat (12) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
